@@ sv/mdp_pkg.sv @@
// Package with the character codes, parse phases, queue sizing and command word type.
`default_nettype none
package mdp_pkg;

    localparam int MAX_DESC_LEN = 256;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_F      = 8'h46;

    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_ARGS  = 3'd1;
    localparam logic [2:0] PH_ARRAY = 3'd2;
    localparam logic [2:0] PH_REF   = 3'd3;
    localparam logic [2:0] PH_RET   = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    localparam logic [1:0] CMD_ARG = 2'd0;
    localparam logic [1:0] CMD_RET = 2'd1;
    localparam logic [1:0] CMD_ERR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] arg_index;
        logic [7:0] begin_pos;
        logic [7:0] end_pos;
        logic [1:0] slot_count;
        logic       is_primitive;
        logic       end_from_len;
        logic [8:0] desc_length;
    } t_cmd;

    function automatic logic is_prim_code(input logic [7:0] c);
        return (c == CH_B) || (c == CH_C) || (c == CH_I) || (c == CH_S) ||
               (c == CH_Z) || (c == CH_F) || (c == CH_D) || (c == CH_J);
    endfunction

    function automatic logic [1:0] prim_slots(input logic [7:0] c);
        return ((c == CH_D) || (c == CH_J)) ? 2'd2 : 2'd1;
    endfunction

endpackage
`default_nettype wire

@@ sv/mdp_ifs.sv @@
// Handshake interfaces for the character input and the result output channels.
`default_nettype none
interface mdp_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] desc_char;
    logic [8:0] desc_length;

    modport source (output valid, start_req, desc_char, desc_length, input ready);
    modport sink   (input valid, start_req, desc_char, desc_length, output ready);
endinterface

interface mdp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] arg_index;
    logic       is_return;
    logic [7:0] begin_pos;
    logic [7:0] end_pos;
    logic [1:0] slot_count;
    logic       is_primitive;
    logic       parse_error;

    modport source (output valid, arg_index, is_return, begin_pos, end_pos, slot_count,
                    is_primitive, parse_error, input ready);
    modport sink   (input valid, arg_index, is_return, begin_pos, end_pos, slot_count,
                    is_primitive, parse_error, output ready);
endinterface
`default_nettype wire

@@ sv/method_descriptor_parser_unit.sv @@
// Top level of the JVM method descriptor parser: front end, command queue and back end.
//
// Usage: descriptor characters arrive one word per cycle on the input channel while
// ready is high, the first character of each descriptor marked by start_req together
// with the descriptor length. The output channel carries one word per complete argument
// type, one for the return type, or a single error word for a malformed descriptor; after
// the return type or an error, characters are taken and dropped until the next start_req.
// A character that completes a type has its command word written into the queue when
// it is accepted; the back end moves the word from the queue into its output register
// when that register is empty or its word is being taken.
// Throughput: one character per cycle while the command queue is not full, set by the
// parse state update in the front end.
// The four-entry command queue lets the front end keep taking characters while the
// receiver stalls; input ready drops only when the queue is full, and output words are
// held stable until taken.
// Reset (i_rst_n low at a clock edge) clears the parse state, empties the queue and
// drops output valid.
`default_nettype none
module method_descriptor_parser_unit
    import mdp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mdp_in_if.sink     i_in,
    mdp_out_if.source  o_out
);

    logic q_ready, push, q_valid, pop;
    t_cmd front_cmd, head_cmd;

    mdp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    mdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mdp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

@@ sv/mdp_front.sv @@
// Front end: accepts descriptor characters, runs the parse state and issues command words.
`default_nettype none
module mdp_front
    import mdp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mdp_in_if.sink     i_in,
    input  wire logic  i_q_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_pos, r_ref_begin, n_ref_begin, r_arg_count, n_arg_count;
    logic [2:0] cur_phase;
    logic [7:0] cur_pos, cur_ref, cur_argc;
    logic       emit;
    logic       accept;
    logic [7:0] c;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.desc_char;

    assign cur_phase = i_in.start_req ? PH_OPEN : r_phase;
    assign cur_pos   = i_in.start_req ? 8'd0 : r_pos;
    assign cur_ref   = i_in.start_req ? 8'd0 : r_ref_begin;
    assign cur_argc  = i_in.start_req ? 8'd0 : r_arg_count;

    always_comb begin
        n_phase     = cur_phase;
        n_ref_begin = cur_ref;
        n_arg_count = cur_argc;
        emit        = 1'b0;
        o_cmd       = '0;
        o_cmd.desc_length = i_in.desc_length;
        case (cur_phase)
            PH_OPEN: begin
                if (c == CH_LPAREN) begin
                    n_phase = PH_ARGS;
                end else begin
                    emit       = 1'b1;
                    o_cmd.kind = CMD_ERR;
                    n_phase    = PH_ERR;
                end
            end
            PH_ARGS: begin
                if (is_prim_code(c)) begin
                    emit               = 1'b1;
                    o_cmd.kind         = CMD_ARG;
                    o_cmd.arg_index    = cur_argc;
                    o_cmd.begin_pos    = cur_pos;
                    o_cmd.end_pos      = cur_pos;
                    o_cmd.slot_count   = prim_slots(c);
                    o_cmd.is_primitive = 1'b1;
                    n_arg_count        = cur_argc + 8'd1;
                end else if (c == CH_L) begin
                    n_ref_begin = cur_pos;
                    n_phase     = PH_REF;
                end else if (c == CH_LBRACK) begin
                    n_ref_begin = cur_pos;
                    n_phase     = PH_ARRAY;
                end else if (c == CH_RPAREN) begin
                    n_phase = PH_RET;
                end
            end
            PH_ARRAY: begin
                if (is_prim_code(c)) begin
                    emit             = 1'b1;
                    o_cmd.kind       = CMD_ARG;
                    o_cmd.arg_index  = cur_argc;
                    o_cmd.begin_pos  = cur_ref;
                    o_cmd.end_pos    = cur_pos;
                    o_cmd.slot_count = 2'd1;
                    n_arg_count      = cur_argc + 8'd1;
                    n_ref_begin      = 8'd0;
                    n_phase          = PH_ARGS;
                end else if (c == CH_L) begin
                    n_phase = PH_REF;
                end else if (c != CH_LBRACK) begin
                    emit       = 1'b1;
                    o_cmd.kind = CMD_ERR;
                    n_phase    = PH_ERR;
                end
            end
            PH_REF: begin
                if (c == CH_SEMI) begin
                    emit             = 1'b1;
                    o_cmd.kind       = CMD_ARG;
                    o_cmd.arg_index  = cur_argc;
                    o_cmd.begin_pos  = cur_ref;
                    o_cmd.end_pos    = cur_pos;
                    o_cmd.slot_count = 2'd1;
                    n_arg_count      = cur_argc + 8'd1;
                    n_ref_begin      = 8'd0;
                    n_phase          = PH_ARGS;
                end
            end
            PH_RET: begin
                emit = 1'b1;
                if (c == CH_V) begin
                    o_cmd.kind         = CMD_RET;
                    o_cmd.begin_pos    = cur_pos;
                    o_cmd.end_pos      = cur_pos;
                    o_cmd.is_primitive = 1'b1;
                    n_phase            = PH_DONE;
                end else if (is_prim_code(c)) begin
                    o_cmd.kind         = CMD_RET;
                    o_cmd.begin_pos    = cur_pos;
                    o_cmd.end_pos      = cur_pos;
                    o_cmd.slot_count   = prim_slots(c);
                    o_cmd.is_primitive = 1'b1;
                    n_phase            = PH_DONE;
                end else if ((c == CH_L) || (c == CH_LBRACK)) begin
                    o_cmd.kind         = CMD_RET;
                    o_cmd.begin_pos    = cur_pos;
                    o_cmd.slot_count   = 2'd1;
                    o_cmd.end_from_len = 1'b1;
                    n_phase            = PH_DONE;
                end else begin
                    o_cmd.kind = CMD_ERR;
                    n_phase    = PH_ERR;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPEN;
            r_pos       <= 8'd0;
            r_ref_begin <= 8'd0;
            r_arg_count <= 8'd0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_pos       <= cur_pos + 8'd1;
            r_ref_begin <= n_ref_begin;
            r_arg_count <= n_arg_count;
        end
    end

    a_err_enters_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_cmd.kind == CMD_ERR) |=> (r_phase == PH_ERR))
        else $error("error word issued without entering the error phase");

    a_no_push_when_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !i_in.start_req |-> (r_phase != PH_DONE) && (r_phase != PH_ERR))
        else $error("word issued after the descriptor had finished");

endmodule
`default_nettype wire

@@ sv/mdp_queue.sv @@
// Short command queue between the parse front end and the result back end.
`default_nettype none
module mdp_queue
    import mdp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_cmd       o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_push_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("word pushed into a full queue");

endmodule
`default_nettype wire

@@ sv/mdp_back.sv @@
// Back end: turns command words into result words and holds them in the output register.
`default_nettype none
module mdp_back
    import mdp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_pop,
    mdp_out_if.source  o_out
);

    logic       r_valid;
    logic [7:0] r_arg_index, r_begin_pos, r_end_pos;
    logic       r_is_return, r_is_primitive, r_parse_error;
    logic [1:0] r_slot_count;
    logic [8:0] clamped;
    logic [7:0] len_end;
    logic       is_err;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    assign clamped = (32'(i_cmd.desc_length) > 32'(MAX_DESC_LEN)) ?
                     9'(MAX_DESC_LEN) : i_cmd.desc_length;
    assign len_end = (clamped == 9'd0) ? 8'd0 : 8'(clamped - 9'd1);
    assign is_err  = (i_cmd.kind == CMD_ERR);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_arg_index    <= is_err ? 8'd0 : i_cmd.arg_index;
            r_is_return    <= (i_cmd.kind == CMD_RET);
            r_begin_pos    <= is_err ? 8'd0 : i_cmd.begin_pos;
            r_end_pos      <= is_err ? 8'd0 :
                              (i_cmd.end_from_len ? len_end : i_cmd.end_pos);
            r_slot_count   <= is_err ? 2'd0 : i_cmd.slot_count;
            r_is_primitive <= is_err ? 1'b0 : i_cmd.is_primitive;
            r_parse_error  <= is_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.arg_index    = r_arg_index;
    assign o_out.is_return    = r_is_return;
    assign o_out.begin_pos    = r_begin_pos;
    assign o_out.end_pos      = r_end_pos;
    assign o_out.slot_count   = r_slot_count;
    assign o_out.is_primitive = r_is_primitive;
    assign o_out.parse_error  = r_parse_error;

    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_parse_error |-> (r_arg_index == 8'd0) && !r_is_return &&
            (r_begin_pos == 8'd0) && (r_end_pos == 8'd0) && (r_slot_count == 2'd0))
        else $error("error word carries nonzero fields");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the method descriptor parser: random descriptors, stalls and checks.
module tb;
    import mdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_X = "X";
    localparam logic [7:0] CH_UPPER_Q = "Q";

    typedef struct packed {
        logic [7:0] arg_index;
        logic       is_return;
        logic [7:0] begin_pos;
        logic [7:0] end_pos;
        logic [1:0] slot_count;
        logic       is_primitive;
        logic       parse_error;
    } t_type_word;

    class descriptor_tracker;
        logic [2:0] phase;
        logic [7:0] char_pos;
        logic [7:0] ref_pos;
        logic [7:0] args_seen;
        t_type_word type_words[$];
        int         errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            phase     = PH_OPEN;
            char_pos  = 8'd0;
            ref_pos   = 8'd0;
            args_seen = 8'd0;
        endfunction

        function bit prim_code(logic [7:0] ch);
            case (ch)
                CH_B, CH_C, CH_I, CH_S, CH_Z, CH_F, CH_D, CH_J: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [1:0] slots_of(logic [7:0] ch);
            return (ch == CH_D || ch == CH_J) ? 2'd2 : 2'd1;
        endfunction

        function void take_char(logic start, logic [7:0] ch, logic [8:0] len);
            t_type_word  w;
            bit          emit;
            int unsigned clamped;
            w = '0;
            emit = 1'b0;
            if (start) begin
                restart();
            end
            case (phase)
                PH_OPEN: begin
                    if (ch == CH_LPAREN) begin
                        phase = PH_ARGS;
                    end else begin
                        w.parse_error = 1'b1;
                        emit = 1'b1;
                        phase = PH_ERR;
                    end
                end
                PH_ARGS: begin
                    if (prim_code(ch)) begin
                        w.arg_index = args_seen;
                        w.begin_pos = char_pos;
                        w.end_pos = char_pos;
                        w.slot_count = slots_of(ch);
                        w.is_primitive = 1'b1;
                        emit = 1'b1;
                        args_seen = args_seen + 8'd1;
                    end else if (ch == CH_L) begin
                        ref_pos = char_pos;
                        phase = PH_REF;
                    end else if (ch == CH_LBRACK) begin
                        ref_pos = char_pos;
                        phase = PH_ARRAY;
                    end else if (ch == CH_RPAREN) begin
                        phase = PH_RET;
                    end
                end
                PH_ARRAY: begin
                    if (prim_code(ch)) begin
                        w.arg_index = args_seen;
                        w.begin_pos = ref_pos;
                        w.end_pos = char_pos;
                        w.slot_count = 2'd1;
                        emit = 1'b1;
                        args_seen = args_seen + 8'd1;
                        ref_pos = 8'd0;
                        phase = PH_ARGS;
                    end else if (ch == CH_L) begin
                        phase = PH_REF;
                    end else if (ch != CH_LBRACK) begin
                        w.parse_error = 1'b1;
                        emit = 1'b1;
                        phase = PH_ERR;
                    end
                end
                PH_REF: begin
                    if (ch == CH_SEMI) begin
                        w.arg_index = args_seen;
                        w.begin_pos = ref_pos;
                        w.end_pos = char_pos;
                        w.slot_count = 2'd1;
                        emit = 1'b1;
                        args_seen = args_seen + 8'd1;
                        ref_pos = 8'd0;
                        phase = PH_ARGS;
                    end
                end
                PH_RET: begin
                    emit = 1'b1;
                    w.is_return = 1'b1;
                    w.begin_pos = char_pos;
                    w.end_pos = char_pos;
                    if (ch == CH_V) begin
                        w.is_primitive = 1'b1;
                        phase = PH_DONE;
                    end else if (prim_code(ch)) begin
                        w.slot_count = slots_of(ch);
                        w.is_primitive = 1'b1;
                        phase = PH_DONE;
                    end else if (ch == CH_L || ch == CH_LBRACK) begin
                        clamped = (len > MAX_DESC_LEN) ? MAX_DESC_LEN : len;
                        w.end_pos = (clamped == 0) ? 8'd0 : 8'(clamped - 1);
                        w.slot_count = 2'd1;
                        phase = PH_DONE;
                    end else begin
                        w = '0;
                        w.parse_error = 1'b1;
                        phase = PH_ERR;
                    end
                end
                default: begin
                end
            endcase
            char_pos = char_pos + 8'd1;
            if (emit) begin
                type_words.push_back(w);
            end
        endfunction

        function void field_diff(string name, logic [8:0] want, logic [8:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_word(t_type_word got);
            t_type_word want;
            if (type_words.size() == 0) begin
                $error("result word with no type pending: %h", got);
                errors++;
                return;
            end
            want = type_words.pop_front();
            field_diff("arg_index", 9'(want.arg_index), 9'(got.arg_index));
            field_diff("is_return", 9'(want.is_return), 9'(got.is_return));
            field_diff("begin_pos", 9'(want.begin_pos), 9'(got.begin_pos));
            field_diff("end_pos", 9'(want.end_pos), 9'(got.end_pos));
            field_diff("slot_count", 9'(want.slot_count), 9'(got.slot_count));
            field_diff("is_primitive", 9'(want.is_primitive), 9'(got.is_primitive));
            field_diff("parse_error", 9'(want.parse_error), 9'(got.parse_error));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mdp_in_if  in_if ();
    mdp_out_if out_if ();

    method_descriptor_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    descriptor_tracker tracker = new();
    t_type_word        seen_word;
    bit                idle_on = 1'b1;
    int                chars_sent = 0;
    logic [7:0]        txt[$];
    logic [7:0]        prim_set[8] = '{CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z};

    assign seen_word = {out_if.arg_index, out_if.is_return, out_if.begin_pos, out_if.end_pos,
                        out_if.slot_count, out_if.is_primitive, out_if.parse_error};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                tracker.take_char(in_if.start_req, in_if.desc_char, in_if.desc_length);
            end
            if (out_if.valid && out_if.ready) begin
                tracker.match_word(seen_word);
            end
        end
    end

    initial begin
        out_if.ready <= 1'b1;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_char(input logic start, input logic [7:0] ch, input logic [8:0] len);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.start_req   <= start;
        in_if.desc_char   <= ch;
        in_if.desc_length <= len;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        chars_sent++;
    endtask

    task automatic send_desc(input bit with_start, input logic [8:0] len);
        foreach (txt[i]) begin
            send_char(with_start && i == 0, txt[i], len);
        end
    endtask

    function automatic logic [7:0] any_prim();
        return prim_set[$urandom_range(0, 7)];
    endfunction

    function automatic void put_class_ref();
        int         n;
        logic [7:0] ch;
        n = $urandom_range(0, 4);
        txt.push_back(CH_L);
        repeat (n) begin
            do ch = 8'($urandom_range(0, 255)); while (ch == CH_SEMI);
            txt.push_back(ch);
        end
        txt.push_back(CH_SEMI);
    endfunction

    function automatic void put_arg_type();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: txt.push_back(any_prim());
            5, 6: put_class_ref();
            7, 8: begin
                repeat ($urandom_range(1, 3)) txt.push_back(CH_LBRACK);
                if ($urandom_range(0, 2) == 0) begin
                    put_class_ref();
                end else begin
                    txt.push_back(any_prim());
                end
            end
            default: txt.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void build_method();
        txt.push_back(CH_LPAREN);
        repeat ($urandom_range(0, 6)) put_arg_type();
        txt.push_back(CH_RPAREN);
        case ($urandom_range(0, 5))
            0: txt.push_back(CH_V);
            1, 2: txt.push_back(any_prim());
            3: put_class_ref();
            4: begin
                txt.push_back(CH_LBRACK);
                txt.push_back(any_prim());
            end
            default: txt.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        int         sel;
        int         cut;
        bit         long_done;
        logic [8:0] len;

        long_done = 1'b0;
        i_rst_n <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.start_req   <= 1'b0;
        in_if.desc_char   <= 8'd0;
        in_if.desc_length <= 9'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        txt = '{CH_LPAREN, CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z, CH_RPAREN, CH_LBRACK};
        send_desc(1'b1, 9'd1);
        txt = '{CH_LPAREN, CH_V, CH_L, CH_SEMI, CH_LBRACK, CH_LBRACK, CH_J, CH_RPAREN, CH_L, CH_I};
        send_desc(1'b1, 9'd256);
        txt = '{CH_UPPER_A, CH_I};
        send_desc(1'b1, 9'd2);
        txt = '{CH_LPAREN, CH_LBRACK, CH_UPPER_X};
        send_desc(1'b1, 9'd3);
        txt = '{CH_LPAREN, CH_RPAREN, CH_UPPER_Q};
        send_desc(1'b1, 9'd3);

        while (chars_sent < 1300) begin
            if (chars_sent > 1100) begin
                idle_on = 1'b0;
            end
            txt.delete();
            sel = $urandom_range(0, 9);
            if (!long_done && chars_sent > 500) begin
                // A long argument list wraps both the position and the argument counter.
                txt.push_back(CH_LPAREN);
                repeat (300) txt.push_back(any_prim());
                txt.push_back(CH_RPAREN);
                txt.push_back(CH_L);
                long_done = 1'b1;
                send_desc(1'b1, 9'($urandom_range(1, 256)));
            end else if (sel <= 7) begin
                build_method();
                if (sel == 7) begin
                    cut = $urandom_range(1, txt.size());
                    while (txt.size() > cut) void'(txt.pop_back());
                end
                if ($urandom_range(0, 1) == 0) begin
                    len = 9'(txt.size());
                end else begin
                    len = 9'($urandom_range(1, 256));
                end
                send_desc(1'b1, len);
            end else begin
                repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0) begin
                    txt[0] = CH_LPAREN;
                end
                send_desc(1'($urandom_range(0, 1)), 9'($urandom_range(1, 256)));
            end
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.type_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.type_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ method_descriptor_parser_unit.f @@
sv/mdp_pkg.sv
sv/mdp_ifs.sv
sv/mdp_front.sv
sv/mdp_queue.sv
sv/mdp_back.sv
sv/method_descriptor_parser_unit.sv
tb/sv/tb.sv
